FILE: sv/tc_pkg.sv
// Shared widths, constants and types for the triangle centers pipeline.
`default_nettype none
package tc_pkg;

  localparam int CRD_W   = 32;
  localparam int DIF_W   = CRD_W + 1;
  localparam int DF2_W   = CRD_W + 2;
  localparam int PRD_W   = 2 * DIF_W;
  localparam int ACC_W   = PRD_W + 1;
  localparam int WLO_W   = DF2_W;
  localparam int WPR_W   = ACC_W + DF2_W;
  localparam int NUM_W   = WPR_W + 1;
  localparam int DEN_W   = ACC_W + 1;
  localparam int QBITS   = 50;
  localparam int QUO_W   = QBITS + 1;
  localparam int SUM_W   = QBITS + 2;
  localparam int OUT_W   = 48;
  localparam int DIV_LAT = QBITS + 4;
  localparam int TX_W    = CRD_W + 1;
  localparam int GX_W    = TX_W + DF2_W;
  localparam int THIRD_SH = 35;

  localparam logic [DF2_W-1:0] THIRD_MUL =
    DF2_W'(((64'd1 << THIRD_SH) + 64'd1) / 64'd3);

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [CRD_W-1:0] pax;
    logic signed [CRD_W-1:0] pay;
    logic signed [OUT_W-1:0] cent_x;
    logic signed [OUT_W-1:0] cent_y;
    logic                    degen;
  } side_t;

endpackage
`default_nettype wire

FILE: sv/tc_wmul.sv
// Two-stage signed multiplier for a wide operand times a narrow one.
`default_nettype none
module tc_wmul (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [tc_pkg::ACC_W-1:0]  a_i,
  input  logic signed [tc_pkg::DF2_W-1:0]  b_i,
  output logic signed [tc_pkg::WPR_W-1:0]  p_o
);
  import tc_pkg::*;

  localparam int HI_W = ACC_W - WLO_W;
  localparam int PL_W = WLO_W + 1 + DF2_W;
  localparam int PH_W = HI_W + DF2_W;

  logic signed [PL_W-1:0]  pl_r;
  logic signed [PH_W-1:0]  ph_r;
  logic signed [WPR_W-1:0] p_r;
  logic signed [WPR_W-1:0] p_nxt;
  logic signed [WLO_W:0]   lo;
  logic signed [HI_W-1:0]  hi;

  assign lo = $signed({1'b0, a_i[WLO_W-1:0]});
  assign hi = $signed(a_i[ACC_W-1:WLO_W]);
  assign p_nxt = $signed({ph_r, {WLO_W{1'b0}}}) + WPR_W'(pl_r);

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= lo * b_i;
      ph_r <= hi * b_i;
      p_r  <= p_nxt;
    end
  end

  assign p_o = p_r;

endmodule
`default_nettype wire

FILE: sv/tc_div.sv
// Pipelined restoring divider giving a signed quotient rounded half away from zero.
`default_nettype none
module tc_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [tc_pkg::NUM_W-1:0]  num_i,
  input  logic signed [tc_pkg::DEN_W-1:0]  den_i,
  output logic signed [tc_pkg::QUO_W-1:0]  quot_o
);
  import tc_pkg::*;

  localparam int NM_W  = NUM_W + 2;
  localparam int DN_W  = DEN_W + 1;
  localparam int CMP_W = DN_W + QBITS;
  localparam logic [QBITS-1:0] QMAX = {QBITS{1'b1}};

  logic [NUM_W-1:0] an_r;
  logic [DEN_W-1:0] am_r;
  logic             ng1_r;
  logic [NM_W-1:0]  nm_r;
  logic [DN_W-1:0]  dn_r;
  logic             ng2_r;

  logic [NM_W-1:0]  rr_r [0:QBITS];
  logic [QBITS-1:0] qq_r [0:QBITS];
  logic [DN_W-1:0]  dd_r [0:QBITS];
  logic             ng_r [0:QBITS];
  logic             ov_r [0:QBITS];

  logic signed [QUO_W-1:0] mag_nxt;
  logic signed [QUO_W-1:0] quot_nxt;
  logic signed [QUO_W-1:0] quot_r;

  always_ff @(posedge clk) begin
    if (en) begin
      an_r  <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      am_r  <= den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
      ng1_r <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
      nm_r  <= {1'b0, an_r, 1'b0} + NM_W'(am_r);
      dn_r  <= {am_r, 1'b0};
      ng2_r <= ng1_r;
      rr_r[0] <= nm_r;
      qq_r[0] <= '0;
      dd_r[0] <= dn_r;
      ng_r[0] <= ng2_r;
      ov_r[0] <= CMP_W'(nm_r) >= (CMP_W'(dn_r) << QBITS);
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_step
    localparam int BI = QBITS - 1 - k;
    logic [CMP_W-1:0] dsh;
    logic             hit;
    assign dsh = CMP_W'(dd_r[k]) << BI;
    assign hit = CMP_W'(rr_r[k]) >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rr_r[k+1] <= hit ? rr_r[k] - dsh[NM_W-1:0] : rr_r[k];
        qq_r[k+1] <= hit ? (qq_r[k] | (QBITS'(1) << BI)) : qq_r[k];
        dd_r[k+1] <= dd_r[k];
        ng_r[k+1] <= ng_r[k];
        ov_r[k+1] <= ov_r[k];
      end
    end
  end

  assign mag_nxt  = ov_r[QBITS] ? $signed({1'b0, QMAX}) : $signed({1'b0, qq_r[QBITS]});
  assign quot_nxt = ng_r[QBITS] ? -mag_nxt : mag_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      quot_r <= quot_nxt;
    end
  end

  assign quot_o = quot_r;

endmodule
`default_nettype wire

FILE: sv/triangle_centers_core.sv
// Top level: centroid, orthocenter and circumcenter of one triangle per word.
//
//   channel | direction | words
//   in_     | input     | ax, ay, bx, by, cx, cy
//   out_    | output    | six center coordinates, degenerate, saturated
//
// One word enters per cycle while out_ is not stalled.
// Latency is set by the four parallel bit-per-stage dividers, one quotient bit a stage.
// Reset clears only the valid bits of the pipeline.
// A stall on out_ holds the whole pipeline, and in_ready falls with it.
`default_nettype none
module triangle_centers_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [tc_pkg::CRD_W-1:0]  in_ax,
  input  logic signed [tc_pkg::CRD_W-1:0]  in_ay,
  input  logic signed [tc_pkg::CRD_W-1:0]  in_bx,
  input  logic signed [tc_pkg::CRD_W-1:0]  in_by,
  input  logic signed [tc_pkg::CRD_W-1:0]  in_cx,
  input  logic signed [tc_pkg::CRD_W-1:0]  in_cy,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [tc_pkg::OUT_W-1:0]  out_centroid_x,
  output logic signed [tc_pkg::OUT_W-1:0]  out_centroid_y,
  output logic signed [tc_pkg::OUT_W-1:0]  out_ortho_x,
  output logic signed [tc_pkg::OUT_W-1:0]  out_ortho_y,
  output logic signed [tc_pkg::OUT_W-1:0]  out_circum_x,
  output logic signed [tc_pkg::OUT_W-1:0]  out_circum_y,
  output logic                             out_degenerate,
  output logic                             out_saturated
);
  import tc_pkg::*;

  localparam int NV     = 8 + DIV_LAT;
  localparam int SIDE_N = 2 + DIV_LAT;

  function automatic logic [OUT_W:0] clip(input logic signed [SUM_W-1:0] v);
    logic [OUT_W:0] res;
    if (v > SUM_W'(OUT_MAX)) begin
      res = {1'b1, OUT_MAX};
    end else if (v < SUM_W'(OUT_MIN)) begin
      res = {1'b1, OUT_MIN};
    end else begin
      res = {1'b0, v[OUT_W-1:0]};
    end
    return res;
  endfunction

  logic          en;
  logic [NV:1]   vld_r;

  logic signed [CRD_W-1:0] ax1_r, ay1_r, bx1_r, by1_r, cx1_r, cy1_r;
  logic signed [DIF_W-1:0] dbx2_r, dby2_r, dcx2_r, dcy2_r;
  logic signed [DF2_W-1:0] ey2_r, ex2_r, sx2_r, sy2_r;
  logic signed [CRD_W-1:0] ax2_r, ay2_r;

  logic signed [PRD_W-1:0] m_bxcy3_r, m_bycx3_r, m_bxbx3_r, m_byby3_r;
  logic signed [PRD_W-1:0] m_cxcx3_r, m_cycy3_r, m_bxcx3_r, m_bycy3_r;
  logic [TX_W-1:0]         tx3_r, ty3_r;
  logic                    txn3_r, tyn3_r;
  logic signed [DF2_W-1:0] ey3_r, ex3_r;
  logic signed [DIF_W-1:0] dbx3_r, dby3_r, dcx3_r, dcy3_r;
  logic signed [CRD_W-1:0] ax3_r, ay3_r;

  logic signed [ACC_W-1:0] det4_r, b24_r, c24_r, dot4_r;
  logic [GX_W-1:0]         gx4_r, gy4_r;
  logic                    gxn4_r, gyn4_r;
  logic signed [DF2_W-1:0] ey4_r, ex4_r;
  logic signed [DIF_W-1:0] dbx4_r, dby4_r, dcx4_r, dcy4_r;
  logic signed [CRD_W-1:0] ax4_r, ay4_r;

  logic signed [WPR_W-1:0] wp0, wp1, wp2, wp3, wp4, wp5;
  logic signed [ACC_W-1:0] det5_r, det6_r;
  logic signed [NUM_W-1:0] nox7_r, noy7_r, ncx7_r, ncy7_r;
  logic signed [DEN_W-1:0] dm7_r, dm27_r;
  logic signed [QUO_W-1:0] qox, qoy, qcx, qcy;

  logic signed [OUT_W-1:0] cmx_nxt, cmy_nxt, cex_nxt, cey_nxt;
  side_t                   side_nxt;
  side_t                   side_r [0:SIDE_N];
  side_t                   sd;

  logic [OUT_W:0] kox_nxt, koy_nxt, kcx_nxt, kcy_nxt;

  logic signed [OUT_W-1:0] cent_x_r, cent_y_r, ortho_x_r, ortho_y_r, circ_x_r, circ_y_r;
  logic                    degen_r, sat_r;

  assign en       = !vld_r[NV] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NV-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r <= in_ax;
      ay1_r <= in_ay;
      bx1_r <= in_bx;
      by1_r <= in_by;
      cx1_r <= in_cx;
      cy1_r <= in_cy;

      dbx2_r <= DIF_W'(bx1_r) - DIF_W'(ax1_r);
      dby2_r <= DIF_W'(by1_r) - DIF_W'(ay1_r);
      dcx2_r <= DIF_W'(cx1_r) - DIF_W'(ax1_r);
      dcy2_r <= DIF_W'(cy1_r) - DIF_W'(ay1_r);
      ey2_r  <= DF2_W'(cy1_r) - DF2_W'(by1_r);
      ex2_r  <= DF2_W'(bx1_r) - DF2_W'(cx1_r);
      sx2_r  <= DF2_W'(ax1_r) + DF2_W'(bx1_r) + DF2_W'(cx1_r);
      sy2_r  <= DF2_W'(ay1_r) + DF2_W'(by1_r) + DF2_W'(cy1_r);
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;

      m_bxcy3_r <= dbx2_r * dcy2_r;
      m_bycx3_r <= dby2_r * dcx2_r;
      m_bxbx3_r <= dbx2_r * dbx2_r;
      m_byby3_r <= dby2_r * dby2_r;
      m_cxcx3_r <= dcx2_r * dcx2_r;
      m_cycy3_r <= dcy2_r * dcy2_r;
      m_bxcx3_r <= dbx2_r * dcx2_r;
      m_bycy3_r <= dby2_r * dcy2_r;
      tx3_r  <= (sx2_r[DF2_W-1] ? TX_W'(-sx2_r) : TX_W'(sx2_r)) + TX_W'(1);
      ty3_r  <= (sy2_r[DF2_W-1] ? TX_W'(-sy2_r) : TX_W'(sy2_r)) + TX_W'(1);
      txn3_r <= sx2_r[DF2_W-1];
      tyn3_r <= sy2_r[DF2_W-1];
      ey3_r  <= ey2_r;
      ex3_r  <= ex2_r;
      dbx3_r <= dbx2_r;
      dby3_r <= dby2_r;
      dcx3_r <= dcx2_r;
      dcy3_r <= dcy2_r;
      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;

      det4_r <= ACC_W'(m_bxcy3_r) - ACC_W'(m_bycx3_r);
      b24_r  <= ACC_W'(m_bxbx3_r) + ACC_W'(m_byby3_r);
      c24_r  <= ACC_W'(m_cxcx3_r) + ACC_W'(m_cycy3_r);
      dot4_r <= ACC_W'(m_bxcx3_r) + ACC_W'(m_bycy3_r);
      gx4_r  <= GX_W'(tx3_r) * GX_W'(THIRD_MUL);
      gy4_r  <= GX_W'(ty3_r) * GX_W'(THIRD_MUL);
      gxn4_r <= txn3_r;
      gyn4_r <= tyn3_r;
      ey4_r  <= ey3_r;
      ex4_r  <= ex3_r;
      dbx4_r <= dbx3_r;
      dby4_r <= dby3_r;
      dcx4_r <= dcx3_r;
      dcy4_r <= dcy3_r;
      ax4_r  <= ax3_r;
      ay4_r  <= ay3_r;

      det5_r <= det4_r;
      det6_r <= det5_r;

      nox7_r <= NUM_W'(wp0);
      noy7_r <= NUM_W'(wp1);
      ncx7_r <= NUM_W'(wp2) - NUM_W'(wp3);
      ncy7_r <= NUM_W'(wp4) - NUM_W'(wp5);
      dm7_r  <= DEN_W'(det6_r);
      dm27_r <= $signed({det6_r, 1'b0});
    end
  end

  tc_wmul u_wm0 (.clk(clk), .en(en), .a_i(dot4_r), .b_i(ey4_r), .p_o(wp0));
  tc_wmul u_wm1 (.clk(clk), .en(en), .a_i(dot4_r), .b_i(ex4_r), .p_o(wp1));
  tc_wmul u_wm2 (.clk(clk), .en(en), .a_i(b24_r), .b_i(DF2_W'(dcy4_r)), .p_o(wp2));
  tc_wmul u_wm3 (.clk(clk), .en(en), .a_i(c24_r), .b_i(DF2_W'(dby4_r)), .p_o(wp3));
  tc_wmul u_wm4 (.clk(clk), .en(en), .a_i(c24_r), .b_i(DF2_W'(dbx4_r)), .p_o(wp4));
  tc_wmul u_wm5 (.clk(clk), .en(en), .a_i(b24_r), .b_i(DF2_W'(dcx4_r)), .p_o(wp5));

  tc_div u_dv_ox (.clk(clk), .en(en), .num_i(nox7_r), .den_i(dm7_r),  .quot_o(qox));
  tc_div u_dv_oy (.clk(clk), .en(en), .num_i(noy7_r), .den_i(dm7_r),  .quot_o(qoy));
  tc_div u_dv_cx (.clk(clk), .en(en), .num_i(ncx7_r), .den_i(dm27_r), .quot_o(qcx));
  tc_div u_dv_cy (.clk(clk), .en(en), .num_i(ncy7_r), .den_i(dm27_r), .quot_o(qcy));

  assign cmx_nxt = $signed({{(OUT_W-CRD_W){1'b0}}, gx4_r[THIRD_SH +: CRD_W]});
  assign cmy_nxt = $signed({{(OUT_W-CRD_W){1'b0}}, gy4_r[THIRD_SH +: CRD_W]});
  assign cex_nxt = gxn4_r ? -cmx_nxt : cmx_nxt;
  assign cey_nxt = gyn4_r ? -cmy_nxt : cmy_nxt;

  always_comb begin
    side_nxt.pax    = ax4_r;
    side_nxt.pay    = ay4_r;
    side_nxt.cent_x = cex_nxt;
    side_nxt.cent_y = cey_nxt;
    side_nxt.degen  = (det4_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int j = 1; j <= SIDE_N; j++) begin
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign sd = side_r[SIDE_N];

  assign kox_nxt = clip(SUM_W'(sd.pax) + SUM_W'(qox));
  assign koy_nxt = clip(SUM_W'(sd.pay) + SUM_W'(qoy));
  assign kcx_nxt = clip(SUM_W'(sd.pax) + SUM_W'(qcx));
  assign kcy_nxt = clip(SUM_W'(sd.pay) + SUM_W'(qcy));

  always_ff @(posedge clk) begin
    if (en) begin
      if (sd.degen) begin
        cent_x_r  <= '0;
        cent_y_r  <= '0;
        ortho_x_r <= '0;
        ortho_y_r <= '0;
        circ_x_r  <= '0;
        circ_y_r  <= '0;
        sat_r     <= 1'b0;
      end else begin
        cent_x_r  <= sd.cent_x;
        cent_y_r  <= sd.cent_y;
        ortho_x_r <= $signed(kox_nxt[OUT_W-1:0]);
        ortho_y_r <= $signed(koy_nxt[OUT_W-1:0]);
        circ_x_r  <= $signed(kcx_nxt[OUT_W-1:0]);
        circ_y_r  <= $signed(kcy_nxt[OUT_W-1:0]);
        sat_r     <= kox_nxt[OUT_W] | koy_nxt[OUT_W] | kcx_nxt[OUT_W] | kcy_nxt[OUT_W];
      end
      degen_r <= sd.degen;
    end
  end

  assign out_valid      = vld_r[NV];
  assign out_centroid_x = cent_x_r;
  assign out_centroid_y = cent_y_r;
  assign out_ortho_x    = ortho_x_r;
  assign out_ortho_y    = ortho_y_r;
  assign out_circum_x   = circ_x_r;
  assign out_circum_y   = circ_y_r;
  assign out_degenerate = degen_r;
  assign out_saturated  = sat_r;

endmodule
`default_nettype wire
